[hdl/rc4_pkg.sv]
// Shared types and constants for the RC4 engine.
// Used by rc4_front, rc4_core and the top level; depends on nothing.
`default_nettype none

package rc4_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned PERM_DEPTH = 256;

    typedef enum logic {
        OP_KEY  = 1'b0,
        OP_DATA = 1'b1
    } t_op;

    // One classified input item as it waits in the queue.
    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_item;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

endpackage

`default_nettype wire

[hdl/rc4_front.sv]
// Front end of the RC4 engine: accepts input beats, classifies them and
// holds them in a two-entry queue for the back end. Depends on rc4_pkg.
`default_nettype none

module rc4_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_op,
    input  wire logic [rc4_pkg::BYTE_W-1:0]  i_value,
    input  wire logic                        i_last,
    output rc4_pkg::t_head                   o_head,
    input  wire logic                        i_pop
);
    import rc4_pkg::*;

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_push;
    logic       w_pop;

    // The end-of-key mark means nothing on a data beat, so it is dropped here.
    always_comb begin
        w_item.op    = t_op'(i_op);
        w_item.value = i_value;
        w_item.last  = i_last && (t_op'(i_op) == OP_KEY);
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign w_pop       = i_pop && o_head.valid;
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

`default_nettype wire

[hdl/rc4_core.sv]
// Back end of the RC4 engine: key store, permutation memory, the shared
// swap sequencer for key scheduling and keystream, and the output register.
// Depends on rc4_pkg.
`default_nettype none

module rc4_core #(
    parameter int KEY_MAX = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire rc4_pkg::t_head              i_head,
    output logic                             o_pop,
    output logic                             o_out_valid,
    output logic [rc4_pkg::BYTE_W-1:0]       o_out_byte,
    input  wire logic                        i_out_ready
);
    import rc4_pkg::*;

    localparam int KCW = $clog2(KEY_MAX + 1);
    localparam int KIW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KSA_RD,
        ST_RD_B,
        ST_SWAP,
        ST_FIN
    } t_state;

    t_state            r_state, n_state;
    logic              r_ksa, n_ksa;
    logic [BYTE_W-1:0] r_i, n_i;
    logic [BYTE_W-1:0] r_j, n_j;
    logic [BYTE_W-1:0] r_a, n_a;
    logic [BYTE_W-1:0] r_sa, n_sa;
    logic [BYTE_W-1:0] r_t, n_t;
    logic [BYTE_W-1:0] r_data, n_data;
    logic [KCW-1:0]    r_kcount, n_kcount;
    logic [KIW-1:0]    r_kpos, n_kpos;
    logic [KIW-1:0]    r_kend, n_kend;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;

    // Permutation memory; an entry whose valid bit is clear reads as its index.
    logic [BYTE_W-1:0]     r_perm [PERM_DEPTH];
    logic [PERM_DEPTH-1:0] r_pvalid;
    logic [BYTE_W-1:0]     r_rd_a;
    logic [BYTE_W-1:0]     r_rd_b;
    logic [BYTE_W-1:0]     r_key [KEY_MAX];
    logic [BYTE_W-1:0]     r_key_rd;

    logic              w_we;
    logic [BYTE_W-1:0] w_waddr;
    logic [BYTE_W-1:0] w_wdata;
    logic              w_clr;
    logic              w_rda_en;
    logic [BYTE_W-1:0] w_rda_addr;
    logic              w_rdb_en;
    logic [BYTE_W-1:0] w_rdb_addr;
    logic              w_kwe;
    logic [KIW-1:0]    w_kwaddr;
    logic [KIW-1:0]    w_krd_addr;
    logic [KCW-1:0]    w_kcount_after;
    logic [BYTE_W-1:0] w_kb;
    logic [BYTE_W-1:0] w_b;
    logic [BYTE_W-1:0] w_ks;
    logic [KIW-1:0]    w_kpos_next;

    always_comb begin
        n_state     = r_state;
        n_ksa       = r_ksa;
        n_i         = r_i;
        n_j         = r_j;
        n_a         = r_a;
        n_sa        = r_sa;
        n_t         = r_t;
        n_data      = r_data;
        n_kcount    = r_kcount;
        n_kpos      = r_kpos;
        n_kend      = r_kend;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;
        o_pop       = 1'b0;
        w_clr       = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_a;
        w_wdata     = r_rd_a;
        w_rda_en    = 1'b0;
        w_rda_addr  = r_a;
        w_rdb_en    = 1'b0;
        w_rdb_addr  = r_t;
        w_kwe       = 1'b0;
        w_kwaddr    = r_kcount[KIW-1:0];
        w_krd_addr  = r_kpos;
        w_kcount_after = r_kcount;
        w_kb        = r_ksa ? r_key_rd : '0;
        w_b         = r_j + r_rd_a + w_kb;
        w_ks        = (r_t == r_j) ? r_sa : r_rd_b;
        w_kpos_next = (r_kpos == r_kend) ? '0 : r_kpos + 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    if (i_head.item.op == OP_DATA) begin
                        n_i        = r_i + 1'b1;
                        n_a        = r_i + 1'b1;
                        w_rda_en   = 1'b1;
                        w_rda_addr = r_i + 1'b1;
                        n_data     = i_head.item.value;
                        n_ksa      = 1'b0;
                        n_state    = ST_RD_B;
                    end else begin
                        if (r_kcount < KCW'(KEY_MAX)) begin
                            w_kwe          = 1'b1;
                            w_kcount_after = r_kcount + 1'b1;
                            n_kcount       = w_kcount_after;
                        end
                        if (i_head.item.last) begin
                            // At least one byte is always stored when the key closes.
                            w_clr   = 1'b1;
                            n_ksa   = 1'b1;
                            n_i     = '0;
                            n_j     = '0;
                            n_kpos  = '0;
                            n_kend  = KIW'(w_kcount_after - 1'b1);
                            n_state = ST_KSA_RD;
                        end
                    end
                end
            end
            ST_KSA_RD: begin
                w_rda_en   = 1'b1;
                w_rda_addr = r_i;
                n_a        = r_i;
                w_krd_addr = r_kpos;
                n_state    = ST_RD_B;
            end
            ST_RD_B: begin
                n_sa       = r_rd_a;
                n_j        = w_b;
                w_rda_en   = 1'b1;
                w_rda_addr = w_b;
                n_state    = ST_SWAP;
            end
            ST_SWAP: begin
                // A keystream step only moves on once the output register is free.
                if (r_ksa || !r_out_valid || i_out_ready) begin
                    w_we       = 1'b1;
                    w_waddr    = r_a;
                    w_wdata    = r_rd_a;
                    n_t        = r_sa + r_rd_a;
                    w_rdb_en   = 1'b1;
                    w_rdb_addr = r_sa + r_rd_a;
                    n_state    = ST_FIN;
                end
            end
            ST_FIN: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_sa;
                if (r_ksa) begin
                    if (r_i == '1) begin
                        n_i      = '0;
                        n_j      = '0;
                        n_kcount = '0;
                        n_ksa    = 1'b0;
                        n_state  = ST_IDLE;
                    end else begin
                        n_i        = r_i + 1'b1;
                        n_a        = r_i + 1'b1;
                        w_rda_en   = 1'b1;
                        w_rda_addr = r_i + 1'b1;
                        w_krd_addr = w_kpos_next;
                        n_kpos     = w_kpos_next;
                        n_state    = ST_RD_B;
                    end
                end else begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_data ^ w_ks;
                    // The next data byte starts here; its first read sees this write.
                    if (i_head.valid && i_head.item.op == OP_DATA) begin
                        o_pop      = 1'b1;
                        n_i        = r_i + 1'b1;
                        n_a        = r_i + 1'b1;
                        w_rda_en   = 1'b1;
                        w_rda_addr = r_i + 1'b1;
                        n_data     = i_head.item.value;
                        n_state    = ST_RD_B;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ksa       <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_kcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ksa       <= n_ksa;
            r_i         <= n_i;
            r_j         <= n_j;
            r_kcount    <= n_kcount;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_sa       <= n_sa;
        r_t        <= n_t;
        r_data     <= n_data;
        r_kpos     <= n_kpos;
        r_kend     <= n_kend;
        r_out_byte <= n_out_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= '0;
        end else if (w_clr) begin
            r_pvalid <= '0;
        end else if (w_we) begin
            r_pvalid[w_waddr] <= 1'b1;
        end
    end

    // Both read ports pass a same-cycle write straight through.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_perm[w_waddr] <= w_wdata;
        end
        if (w_rda_en) begin
            if (w_we && w_waddr == w_rda_addr) begin
                r_rd_a <= w_wdata;
            end else begin
                r_rd_a <= r_pvalid[w_rda_addr] ? r_perm[w_rda_addr] : w_rda_addr;
            end
        end
        if (w_rdb_en) begin
            if (w_we && w_waddr == w_rdb_addr) begin
                r_rd_b <= w_wdata;
            end else begin
                r_rd_b <= r_pvalid[w_rdb_addr] ? r_perm[w_rdb_addr] : w_rdb_addr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_kwe) begin
            r_key[w_kwaddr] <= i_head.item.value;
        end
        r_key_rd <= r_key[w_krd_addr];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;

endmodule

`default_nettype wire

[hdl/rc4_stream_cipher_top.sv]
// RC4 stream cipher engine, top level.
// Input beats carry a key byte (tuser = 0) or a data byte (tuser = 1); tlast
// on a key beat closes the key and starts key scheduling. Data before any key
// runs on the identity permutation. Key bytes past KEY_MAX are dropped.
// Each data beat yields one output beat, the data byte XORed with the next
// keystream byte; key beats yield nothing.
// A two-entry queue decouples input acceptance from the processing engine,
// and a single output register holds the result until the receiver takes it.
// Each data byte runs a read, read and swap-write sequence on the permutation
// memory, and the next data byte can start as the previous one finishes; its
// result is loaded into the output register with the final swap write. A key
// byte is stored as it is taken. Closing a key costs 256 steps of that
// sequence, during which the queue fills and s_axis_tready drops.
// If the receiver stalls, the finished byte stays in the output register and
// the next data byte waits just before its swap write.
// Synchronous reset restores the identity permutation, clears both stream
// indices and the key count, and empties the queue and output register.
// Depends on rc4_pkg, rc4_front and rc4_core.
`default_nettype none

module rc4_stream_cipher_top #(
    parameter int KEY_MAX = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [rc4_pkg::BYTE_W-1:0]  s_axis_tdata,   // [7:0] byte_value
    input  wire logic                        s_axis_tlast,   // last_key
    input  wire logic                        s_axis_tuser,   // [0] operation
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [rc4_pkg::BYTE_W-1:0]       m_axis_tdata    // [7:0] out_byte
);
    import rc4_pkg::*;

    t_head w_head;
    logic  w_pop;

    rc4_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tuser),
        .i_value (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    rc4_core #(
        .KEY_MAX (KEY_MAX)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata),
        .i_out_ready (m_axis_tready)
    );

endmodule

`default_nettype wire

[hdl/rc4_checker.sv]
// Port-level checks for the RC4 engine and the bind that attaches them
// to rc4_stream_cipher_top. Depends on nothing else.
`default_nettype none

module rc4_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic [7:0] s_axis_tdata,
    input wire logic       s_axis_tlast,
    input wire logic       s_axis_tuser,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);

    // A stalled output beat keeps its valid and its data.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output beat changed while stalled");

    // A waiting input beat keeps its valid and its fields until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && !s_axis_tready) |=>
            (s_axis_tvalid && $stable({s_axis_tuser, s_axis_tlast, s_axis_tdata})))
        else $error("input beat changed while waiting");

    // Reset leaves the queue empty and no result pending.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (s_axis_tready && !m_axis_tvalid))
        else $error("state after reset is not empty");

    // An output beat that leaves is not followed by another in the next cycle.
    a_out_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("output beats closer than the engine can produce");

    // An output beat never rises straight out of reset.
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(m_axis_tvalid) && $past(i_rst_n, 2) == 1'b0) |-> 1'b0)
        else $error("output beat appeared straight out of reset");

endmodule

bind rc4_stream_cipher_top rc4_checker u_rc4_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for rc4_stream_cipher_top: key and data beats in,
// ciphered bytes out, checked against a cycle-free RC4 predictor kept here.
// Depends on rc4_pkg and the RTL of rc4_stream_cipher_top.
`timescale 1ns / 1ps

module tb_top;
    import rc4_pkg::*;

    localparam int KEY_MAX       = 256;
    localparam int IDLE_LIMIT    = 20000;
    localparam int BACKLOG_HOLD  = 3000;
    localparam int RANDOM_BEATS  = 1250;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] byte_value
    logic       s_axis_tlast  = 1'b0;    // last_key
    logic       s_axis_tuser  = 1'b0;    // [0] operation
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte

    rc4_stream_cipher_top #(.KEY_MAX(KEY_MAX)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state: permutation, stored key and stream indices.
    logic [7:0] sbox [256];
    logic [7:0] key_bytes [KEY_MAX];
    int unsigned key_len = 0;
    logic [7:0] idx_i = 8'h00;
    logic [7:0] idx_j = 8'h00;

    t_item      pending_beats [$];
    logic [7:0] expected_bytes [$];

    int errors        = 0;
    int key_beats     = 0;
    int data_beats    = 0;
    int keys_closed   = 0;
    int long_keys     = 0;
    int bytes_checked = 0;
    int in_beats      = 0;
    int idle_cycles   = 0;
    logic in_taken    = 1'b0;

    // Mostly short gaps, now and then a long one; none at all in calm stretches.
    function automatic int gap_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 20);
        else
            return $urandom_range(30, 120);
    endfunction

    task automatic cipher_step(input t_item beat);
        int unsigned n;
        int unsigned pos;
        int k;
        logic [7:0] jj;
        logic [7:0] tmp;
        logic [7:0] t;
        if (beat.op == OP_KEY) begin
            key_beats++;
            if (key_len < KEY_MAX) begin
                key_bytes[key_len] = beat.value;
                key_len++;
            end
            if (beat.last) begin
                keys_closed++;
                n = (key_len == 0) ? 1 : key_len;
                for (k = 0; k < 256; k++)
                    sbox[k] = k[7:0];
                jj = 8'h00;
                pos = 0;
                for (k = 0; k < 256; k++) begin
                    jj = jj + sbox[k] + key_bytes[pos];
                    tmp = sbox[k];
                    sbox[k] = sbox[jj];
                    sbox[jj] = tmp;
                    pos++;
                    if (pos >= n)
                        pos = 0;
                end
                idx_i = 8'h00;
                idx_j = 8'h00;
                key_len = 0;
            end
        end else begin
            data_beats++;
            idx_i = idx_i + 8'd1;
            idx_j = idx_j + sbox[idx_i];
            tmp = sbox[idx_i];
            sbox[idx_i] = sbox[idx_j];
            sbox[idx_j] = tmp;
            t = sbox[idx_i] + sbox[idx_j];
            expected_bytes.push_back(beat.value ^ sbox[t]);
        end
    endtask

    task automatic queue_beat(input t_op op, input logic [7:0] value, input logic last);
        t_item beat;
        beat.op = op;
        beat.value = value;
        beat.last = last;
        pending_beats.push_back(beat);
    endtask

    // Driver: the next beat goes out on a falling edge once the current one is taken.
    int tx_gap = 0;
    bit tx_calm = 1'b0;
    int tx_cycle = 0;
    t_item tx_beat;

    always @(negedge i_clk) begin
        tx_cycle++;
        if (tx_cycle % 200 == 0)
            tx_calm = ($urandom_range(0, 3) == 0);
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                tx_beat = pending_beats.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= tx_beat.value;
                s_axis_tlast  <= tx_beat.last;
                s_axis_tuser  <= tx_beat.op;
                tx_gap = gap_len(tx_calm);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off so the input side backs up.
    int rx_gap = 0;
    bit rx_calm = 1'b0;
    int rx_cycle = 0;
    int hold_left = 0;
    bit held_off = 1'b0;

    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 200 == 0)
            rx_calm = ($urandom_range(0, 3) == 0);
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!held_off && in_beats >= 400) begin
            held_off = 1'b1;
            hold_left = BACKLOG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            rx_gap = gap_len(rx_calm);
        end
    end

    // Monitor: predict on every accepted input beat, check every output beat.
    t_item rx_item;

    always @(posedge i_clk) begin
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                rx_item.op = t_op'(s_axis_tuser);
                rx_item.value = s_axis_tdata;
                rx_item.last = s_axis_tlast;
                cipher_step(rx_item);
                in_beats++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: out_byte expected none, got %02h", $time, m_axis_tdata);
                    errors++;
                end else begin
                    if (m_axis_tdata !== expected_bytes[0]) begin
                        $display("%0t: out_byte expected %02h, got %02h",
                                 $time, expected_bytes[0], m_axis_tdata);
                        errors++;
                    end
                    void'(expected_bytes.pop_front());
                    bytes_checked++;
                end
            end
        end
    end

    // Watchdog on cycles with work outstanding but no beat moving on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (pending_beats.size() == 0 && !s_axis_tvalid && expected_bytes.size() == 0))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d bytes still expected",
                     $time, idle_cycles, expected_bytes.size());
            $display("rc4_stream_cipher_top: mismatch");
            $finish;
        end
    end

    initial begin
        int r;
        int klen;
        int dlen;
        int k;
        for (k = 0; k < 256; k++)
            sbox[k] = k[7:0];

        // Data before any key runs on the identity permutation; tlast on data is ignored.
        queue_beat(OP_DATA, 8'h00, 1'b0);
        queue_beat(OP_DATA, 8'hFF, 1'b1);
        queue_beat(OP_DATA, 8'h5A, 1'b1);
        queue_beat(OP_DATA, 8'hA5, 1'b0);
        // One-byte key at the top of the byte range.
        queue_beat(OP_KEY,  8'hFF, 1'b1);
        queue_beat(OP_DATA, 8'h00, 1'b0);
        queue_beat(OP_DATA, 8'hFF, 1'b0);
        queue_beat(OP_DATA, 8'h01, 1'b1);
        // Three-byte key spanning the range.
        queue_beat(OP_KEY,  8'h00, 1'b0);
        queue_beat(OP_KEY,  8'h80, 1'b0);
        queue_beat(OP_KEY,  8'hFF, 1'b1);
        queue_beat(OP_DATA, 8'h80, 1'b0);
        queue_beat(OP_DATA, 8'h7F, 1'b0);
        queue_beat(OP_DATA, 8'hFF, 1'b0);
        queue_beat(OP_DATA, 8'h00, 1'b0);
        // All-zero key.
        queue_beat(OP_KEY,  8'h00, 1'b1);
        queue_beat(OP_DATA, 8'hC3, 1'b0);
        queue_beat(OP_DATA, 8'h3C, 1'b0);
        // A new key being loaded leaves the old stream running until it closes.
        queue_beat(OP_KEY,  8'h12, 1'b0);
        queue_beat(OP_DATA, 8'h34, 1'b0);
        queue_beat(OP_DATA, 8'h56, 1'b1);
        queue_beat(OP_KEY,  8'h78, 1'b1);
        queue_beat(OP_DATA, 8'h9A, 1'b0);
        queue_beat(OP_DATA, 8'hBC, 1'b0);

        // Start the random part with a key longer than KEY_MAX.
        klen = $urandom_range(KEY_MAX + 1, KEY_MAX + 44);
        long_keys++;
        for (k = 0; k < klen; k++)
            queue_beat(OP_KEY, 8'($urandom_range(0, 255)), k == klen - 1);
        for (k = 0; k < 20; k++)
            queue_beat(OP_DATA, 8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);

        // Mostly well-formed key-then-message runs, some stray beats in between.
        while (pending_beats.size() < RANDOM_BEATS) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
                if (r < 3) begin
                    dlen = $urandom_range(KEY_MAX - 1, KEY_MAX + 44);
                    if (dlen > KEY_MAX)
                        long_keys++;
                end else if (r < 15) begin
                    dlen = $urandom_range(17, 64);
                end else begin
                    dlen = $urandom_range(1, 16);
                end
                for (k = 0; k < dlen; k++)
                    queue_beat(OP_KEY, 8'($urandom_range(0, 255)), k == dlen - 1);
                dlen = $urandom_range(1, 40);
                for (k = 0; k < dlen; k++)
                    queue_beat(OP_DATA, 8'($urandom_range(0, 255)),
                               $urandom_range(0, 7) == 0);
            end else begin
                queue_beat(t_op'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                           $urandom_range(0, 3) == 0);
            end
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        do @(posedge i_clk);
        while (pending_beats.size() > 0 || s_axis_tvalid || expected_bytes.size() > 0);
        repeat (40) @(posedge i_clk);

        if (expected_bytes.size() > 0) begin
            $display("%0t: %0d expected bytes never arrived", $time, expected_bytes.size());
            errors++;
        end
        $display("Covered %0d key beats closing %0d keys (%0d longer than KEY_MAX),",
                 key_beats, keys_closed, long_keys);
        $display("and %0d data beats with %0d ciphered bytes checked; %0d errors.",
                 data_beats, bytes_checked, errors);
        if (errors == 0)
            $display("rc4_stream_cipher_top: match");
        else
            $display("rc4_stream_cipher_top: mismatch");
        $finish;
    end

endmodule
